>>> sv/stereo_decimate_crossfeed_reverb_assert.svh
// Assertion helpers shared by the RTL files.
`ifndef STEREO_DECIMATE_CROSSFEED_REVERB_ASSERT_SVH
`define STEREO_DECIMATE_CROSSFEED_REVERB_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define SDCR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define SDCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/sdcr_pkg.sv
package sdcr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 11;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One stereo frame moving between the crossfeed and the reverb stage.
  typedef struct packed {
    logic    valid;
    sample_t left;
    sample_t right;
  } frame_t;

  // (3 * a + b) >>> 2, arithmetic; the result stays in the 16-bit range.
  function automatic sample_t mix3(input sample_t a, input sample_t b);
    logic signed [SAMPLE_W+1:0] s;
    s = {{2{a[SAMPLE_W-1]}}, a} + {a[SAMPLE_W-1], a, 1'b0} + {{2{b[SAMPLE_W-1]}}, b};
    return s[SAMPLE_W+1:2];
  endfunction

endpackage

>>> sv/sdcr_reverb.sv
module sdcr_reverb #(
  parameter int DELAY_WORDS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [sdcr_pkg::CFG_W-1:0]   reverb_length,
  input  sdcr_pkg::frame_t             in,
  output sdcr_pkg::frame_t             out
);
  import sdcr_pkg::*;

  `include "stereo_decimate_crossfeed_reverb_assert.svh"

  localparam int PAIRS  = DELAY_WORDS / 2;
  localparam int SLOT_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int IDX_W  = $clog2(DELAY_WORDS);
  localparam int LEN_W  = (IDX_W + 2 > CFG_W) ? IDX_W + 2 : CFG_W;

  logic [2*SAMPLE_W-1:0] store [PAIRS];
  logic [2*SAMPLE_W-1:0] rd_data;

  logic [SLOT_W-1:0] slot;
  logic [SLOT_W:0]   fill;
  logic [SLOT_W:0]   slot_inc;
  logic [LEN_W-1:0]  len_ext;
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  next_idx;
  logic              rev_on;
  logic              hit;
  logic              rd_en;

  logic              b_valid;
  logic              b_rev;
  logic              b_hit;
  logic [SLOT_W-1:0] b_slot;
  sample_t           b_left;
  sample_t           b_right;

  logic [2*SAMPLE_W-1:0] stored;
  sample_t               rev_left;
  sample_t               rev_right;
  logic                  wr_en;

  // Effective length clamps at the store size; 2 or less bypasses.
  always_comb begin
    len_ext  = LEN_W'(reverb_length);
    eff_len  = (len_ext > LEN_W'(DELAY_WORDS)) ? LEN_W'(DELAY_WORDS) : len_ext;
    rev_on   = eff_len > LEN_W'(2);
    slot_inc = (SLOT_W+1)'(slot) + (SLOT_W+1)'(1);
    next_idx = LEN_W'({slot_inc, 1'b0});
    // Written slots always form a prefix, so a high-water mark tells them apart.
    hit      = (SLOT_W+1)'(slot) < fill;
    rd_en    = in.valid && rev_on;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      fill <= '0;
    end else if (rd_en) begin
      if (next_idx >= eff_len) begin
        slot <= '0;
      end else begin
        slot <= slot_inc[SLOT_W-1:0];
      end
      if ((SLOT_W+1)'(slot) == fill) begin
        fill <= slot_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    b_rev   <= rev_on;
    b_hit   <= hit;
    b_slot  <= slot;
    b_left  <= in.left;
    b_right <= in.right;
  end

  always_comb begin
    stored    = b_hit ? rd_data : '0;
    rev_left  = mix3(b_left, stored[2*SAMPLE_W-1:SAMPLE_W]);
    rev_right = mix3(b_right, stored[SAMPLE_W-1:0]);
    wr_en     = b_valid && b_rev;
  end

  // Beats never arrive back to back, so a write-back never meets a read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[b_slot] <= {rev_right, rev_left};
    end
    if (rd_en) begin
      rd_data <= store[slot];
    end
  end

  assign out.valid = b_valid;
  assign out.left  = b_rev ? rev_left : b_left;
  assign out.right = b_rev ? rev_right : b_right;

  `SDCR_ASSERT_NEXT(a_beat_spacing, clk, rst, in.valid, !in.valid)
  `SDCR_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, fill <= (SLOT_W+1)'(PAIRS))
  `SDCR_ASSERT_IMPL(a_slot_in_prefix, clk, rst, 1'b1, (SLOT_W+1)'(slot) <= fill)
  `SDCR_ASSERT_NEXT(a_bypass_holds_slot, clk, rst, in.valid && !rev_on, $stable(slot))

endmodule

>>> sv/stereo_decimate_crossfeed_reverb.sv
// Stereo 2x decimator with crossfeed and cross-delay reverb. Each input beat
// carries one oversampled frame; one processed frame comes out for every two
// input beats, on the second beat of each pair. The block takes one beat
// per clock while s_axis_tready is high: the delay store is a single-port-write,
// registered-read memory read and written once per output frame while the
// reverb is on, and outputs drain through a two-entry buffer, so input stalls
// only while that buffer and the reverb stage together hold two frames. An
// output frame is registered in the reverb stage, then in the output buffer.
// The delay store needs no clearing pass: a fill mark makes slots not yet
// written read as zero, so the block is ready right after reset. reverb_length
// may be changed only while the block is idle; a length of 2 or less bypasses
// the reverb, and values above DELAY_WORDS act as DELAY_WORDS.
module stereo_decimate_crossfeed_reverb #(
  parameter int DELAY_WORDS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [sdcr_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // left_in[15:0], right_in[31:16]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata   // left_out[15:0], right_out[31:16]
);
  import sdcr_pkg::*;

  `include "stereo_decimate_crossfeed_reverb_assert.svh"

  logic [CFG_W-1:0] reverb_length;

  logic                      phase;
  sample_t                   held_left;
  sample_t                   held_right;
  logic signed [SAMPLE_W-3:0] quarter_left;
  logic signed [SAMPLE_W-3:0] quarter_right;

  logic    accept;
  sample_t in_left;
  sample_t in_right;
  sample_t dec_left;
  sample_t dec_right;
  frame_t  xfeed;
  frame_t  rev;

  logic [2*SAMPLE_W-1:0] fifo [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            cnt;
  logic                  push;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverb_length <= '0;
    end else if (cfg_wr_en) begin
      reverb_length <= cfg_wr_data;
    end
  end

  assign in_left  = s_axis_tdata[SAMPLE_W-1:0];
  assign in_right = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];

  // Hold room for a beat still in the reverb stage.
  assign s_axis_tready = (cnt + {1'b0, rev.valid}) < 2'd2;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    dec_left    = held_left + {{2{in_left[SAMPLE_W-1]}}, in_left[SAMPLE_W-1:2]};
    dec_right   = held_right + {{2{in_right[SAMPLE_W-1]}}, in_right[SAMPLE_W-1:2]};
    xfeed.valid = accept && phase;
    xfeed.left  = mix3(dec_left, dec_right);
    xfeed.right = mix3(dec_right, dec_left);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= 1'b0;
      held_left     <= '0;
      held_right    <= '0;
      quarter_left  <= '0;
      quarter_right <= '0;
    end else if (accept) begin
      phase <= !phase;
      if (!phase) begin
        held_left  <= {{2{quarter_left[SAMPLE_W-3]}}, quarter_left}
                      + {in_left[SAMPLE_W-1], in_left[SAMPLE_W-1:1]};
        held_right <= {{2{quarter_right[SAMPLE_W-3]}}, quarter_right}
                      + {in_right[SAMPLE_W-1], in_right[SAMPLE_W-1:1]};
      end else begin
        quarter_left  <= in_left[SAMPLE_W-1:2];
        quarter_right <= in_right[SAMPLE_W-1:2];
      end
    end
  end

  sdcr_reverb #(
    .DELAY_WORDS (DELAY_WORDS)
  ) u_reverb (
    .clk           (clk),
    .rst           (rst),
    .reverb_length (reverb_length),
    .in            (xfeed),
    .out           (rev)
  );

  assign push = rev.valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= {rev.right, rev.left};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assign m_axis_tvalid = cnt != 2'd0;
  assign m_axis_tdata  = fifo[rd_ptr];

  `SDCR_ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= 2'd2)
  `SDCR_ASSERT_IMPL(a_no_overflow, clk, rst, push, cnt < 2'd2 || pop)
  `SDCR_ASSERT_NEXT(a_pair_to_beat, clk, rst, accept && phase, rev.valid)
  `SDCR_ASSERT_IMPL(a_beat_has_pair, clk, rst, rev.valid, !phase)

endmodule

>>> tb/tb.sv
module tb;
  import sdcr_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int STORE_PAIRS = STORE_DEPTH / 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES = 16;

  typedef struct {
    sample_t left;
    sample_t right;
  } frame_s;

  typedef struct {
    bit             set_len;
    logic [CFG_W-1:0] len;
    sample_t        left;
    sample_t        right;
    bit             fixed;
    sample_t        exp_left;
    sample_t        exp_right;
  } stim_row_s;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata = '0;  // left_in[15:0], right_in[31:16]
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;       // left_out[15:0], right_out[31:16]

  stereo_decimate_crossfeed_reverb #(.DELAY_WORDS(STORE_DEPTH)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk = ~clk;

  // Shadow state of the block
  logic [CFG_W-1:0] echo_length;
  bit               second_frame;
  int               held_l, held_r;
  int               quarter_l, quarter_r;
  logic [31:0]      echo_store [STORE_PAIRS];
  int               echo_index;

  frame_s    pending_frames[$];
  stim_row_s stim_table[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int errors = 0;
  int frames_sent = 0;
  int frames_checked = 0;
  int length_writes = 0;

  // Returns 1 when the frame completes a pair and yields an output frame.
  function automatic bit process_frame(input sample_t l_in, input sample_t r_in,
                                       output frame_s res);
    int l, r, cl, cr, eff, slot;
    logic [31:0] word;
    res.left = '0;
    res.right = '0;
    if (!second_frame) begin
      held_l = quarter_l + (int'(l_in) >>> 1);
      held_r = quarter_r + (int'(r_in) >>> 1);
      second_frame = 1'b1;
      return 1'b0;
    end
    second_frame = 1'b0;
    quarter_l = int'(l_in) >>> 2;
    quarter_r = int'(r_in) >>> 2;
    l = held_l + quarter_l;
    r = held_r + quarter_r;
    cl = (3 * l + r) >>> 2;
    cr = (3 * r + l) >>> 2;
    l = cl;
    r = cr;
    eff = (int'(echo_length) > STORE_DEPTH) ? STORE_DEPTH : int'(echo_length);
    if (eff > 2) begin
      slot = (echo_index >> 1) % STORE_PAIRS;
      word = echo_store[slot];
      // cross the channels: left mixes stored right, right mixes stored left
      l = (3 * l + int'($signed(word[31:16]))) >>> 2;
      r = (3 * r + int'($signed(word[15:0]))) >>> 2;
      echo_store[slot] = {r[15:0], l[15:0]};
      echo_index += 2;
      if (echo_index >= eff) echo_index = 0;
    end
    res.left = sample_t'(l[15:0]);
    res.right = sample_t'(r[15:0]);
    return 1'b1;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return sample_t'(16'sh7fff);
      1: return sample_t'(16'sh8000);
      2: return sample_t'(16'sh0000);
      3: return sample_t'(16'shffff);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic add_row(input bit set_len, input int len, input int l, input int r,
                         input bit fixed, input int el, input int er);
    stim_row_s row;
    row.set_len = set_len;
    row.len = CFG_W'(len);
    row.left = sample_t'(l);
    row.right = sample_t'(r);
    row.fixed = fixed;
    row.exp_left = sample_t'(el);
    row.exp_right = sample_t'(er);
    stim_table.push_back(row);
  endtask

  // Drop valid, wait for every expected frame, then let the pipeline settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] len);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    echo_length = len;
    length_writes++;
  endtask

  task automatic send_frame(input sample_t l, input sample_t r, input bit fixed,
                            input frame_s fixed_res);
    frame_s res;
    bit     has_res;
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r, l};
    // inputs only move at rising edges, so ready seen at the falling edge holds
    forever begin
      @(negedge clk);
      if (s_axis_tready) break;
    end
    @(posedge clk);
    has_res = process_frame(l, r, res);
    if (has_res) pending_frames.push_back(fixed ? fixed_res : res);
    frames_sent++;
  endtask

  always @(posedge clk) m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

  // Check each output beat; values at the falling edge are the ones taken next edge.
  always @(negedge clk) begin
    frame_s want;
    sample_t got_l, got_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_l = m_axis_tdata[15:0];
      got_r = m_axis_tdata[31:16];
      if (pending_frames.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output beat: left %0d right %0d", got_l, got_r);
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (got_l !== want.left) begin
          errors++;
          if (errors <= 10)
            $display("left_out mismatch: expected %0d got %0d", want.left, got_l);
        end
        if (got_r !== want.right) begin
          errors++;
          if (errors <= 10)
            $display("right_out mismatch: expected %0d got %0d", want.right, got_r);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    frame_s fixed_res;
    int     n_items;
    int     len;

    echo_length = '0;
    second_frame = 1'b0;
    held_l = 0;
    held_r = 0;
    quarter_l = 0;
    quarter_r = 0;
    echo_index = 0;
    for (int i = 0; i < STORE_PAIRS; i++) echo_store[i] = '0;

    // after reset the reverb is bypassed
    add_row(0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 1, 0, 0);
    add_row(0, 0, 32767, 32767, 0, 0, 0);
    add_row(0, 0, 32767, 32767, 1, 24574, 24574);
    add_row(0, 0, -32768, -32768, 0, 0, 0);
    add_row(0, 0, -32768, -32768, 1, -16385, -16385);
    add_row(0, 0, 32767, -32768, 0, 0, 0);
    add_row(0, 0, -32768, 32767, 0, 0, 0);
    // shortest active reverb, wraps every other output
    add_row(1, 3, 1234, -4321, 0, 0, 0);
    add_row(0, 0, -1, 1, 0, 0, 0);
    add_row(0, 0, 20000, -20000, 0, 0, 0);
    add_row(0, 0, -7, 32767, 0, 0, 0);
    // above the store size, clamps to the full store
    add_row(1, 1025, 32767, 32767, 0, 0, 0);
    add_row(0, 0, 32767, 32767, 0, 0, 0);
    add_row(0, 0, -32768, 100, 0, 0, 0);
    add_row(0, 0, 555, -32768, 0, 0, 0);
    // bypass holds the index
    add_row(1, 2, 4096, -4096, 0, 0, 0);
    add_row(0, 0, -4096, 4096, 0, 0, 0);
    // shrink to the current index: use the current entry once, then wrap
    add_row(1, 4, 8000, 8000, 0, 0, 0);
    add_row(0, 0, -8000, -8000, 0, 0, 0);
    add_row(0, 0, 300, 301, 0, 0, 0);
    add_row(0, 0, 302, 303, 0, 0, 0);
    add_row(1, 2047, 32767, -32768, 0, 0, 0);
    add_row(0, 0, -32768, 32767, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_length('0);
    foreach (stim_table[i]) begin
      if (stim_table[i].set_len) write_length(stim_table[i].len);
      fixed_res.left = stim_table[i].exp_left;
      fixed_res.right = stim_table[i].exp_right;
      send_frame(stim_table[i].left, stim_table[i].right, stim_table[i].fixed, fixed_res);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: len = 0;
        1: len = 1;
        2: len = 2;
        3: len = 3;
        4: len = 4;
        5: len = 5;
        6: len = 1024;
        7: len = 1025;
        8: len = 2047;
        9: len = $urandom_range(3, 40);
        default: len = (ph % 2) ? $urandom_range(3, 1024) : $urandom_range(0, 2047);
      endcase
      write_length(CFG_W'(len));
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 73; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 73; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase
      n_items = $urandom_range(100, 140);
      for (int k = 0; k < n_items; k++) begin
        // hold off the sender until the output side has drained
        if (ph == 5 && k == n_items / 2) wait_idle();
        send_frame(pick_sample(), pick_sample(), 1'b0, fixed_res);
      end
    end

    stall_pct = 0;
    wait_idle();
    repeat (16) @(posedge clk);
    errors += pending_frames.size();

    $display("Sent %0d input frames, checked %0d output frames across %0d length settings",
             frames_sent, frames_checked, length_writes);
    $display("including bypass, clamped, wrapping and shrunk delay lengths under idle/stall mixes");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/sdcr_pkg.sv
sv/sdcr_reverb.sv
sv/stereo_decimate_crossfeed_reverb.sv
tb/tb.sv
